>>> rtl/cpsp_pkg.sv
// Shared types and constants for the configuration packet stream parser.
package cpsp_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned HdrTypeW = 3;

  // Header word fields
  localparam int unsigned TypeMsb  = 15;
  localparam int unsigned TypeLsb  = 13;
  localparam int unsigned OpMsb    = 12;
  localparam int unsigned OpLsb    = 11;
  localparam int unsigned AddrMsb  = 10;
  localparam int unsigned AddrLsb  = 5;
  localparam int unsigned CntMsb   = 4;
  localparam int unsigned CntLsb   = 0;

  // Header type codes
  localparam logic [HdrTypeW-1:0] HdrPad   = 3'h0;
  localparam logic [HdrTypeW-1:0] HdrType1 = 3'h1;
  localparam logic [HdrTypeW-1:0] HdrType2 = 3'h2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CNT_HI = 3'd1,
    PH_CNT_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_HALTED = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAD     = 3'd0,
    KIND_TYPE1   = 3'd1,
    KIND_TYPE2   = 3'd2,
    KIND_COUNT   = 3'd3,
    KIND_DATA    = 3'd4,
    KIND_INVALID = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [OpW-1:0]     op;
    logic [AddrW-1:0]   addr;
    logic [WordW-1:0]   word;
    logic               pkt_end;
    logic               halted;
  } result_t;

endpackage

>>> rtl/config_packet_stream_parser_top.sv
// Configuration packet stream parser: tags each 16-bit stream word with its role.
//
// Each accepted request is one 16-bit configuration word; each produces exactly
// one tagged result in the same order. Header words (bits 15..13) select pad,
// type 1 (opcode, address and a 5-bit count) or type 2 (opcode and address,
// then a high and a low count word forming a 32-bit count). The counted data
// words follow and carry the held opcode and address, and the word that
// completes a packet has packet_end set. An unknown header type halts the
// parser: from that word on every result is tagged invalid with halted set,
// until reset. Throughput is one word per clock while the output is not stalled:
// a word is held in the input register, is classified by a single pass of logic
// against the parser state (bounded by the 32-bit remaining-count decrement),
// and lands in the result register. Both stages advance on their own, so a new
// request is taken while a finished result waits to be taken.
module config_packet_stream_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cpsp_pkg::WordW-1:0]   word_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   word_kind_o,
  output logic [cpsp_pkg::OpW-1:0]     op_code_o,
  output logic [cpsp_pkg::AddrW-1:0]   reg_address_o,
  output logic [cpsp_pkg::WordW-1:0]   word_out_o,
  output logic                         packet_end_o,
  output logic                         halted_o
);

  // Input register
  logic                        s1_valid_q, s1_valid_d;
  logic [cpsp_pkg::WordW-1:0]  s1_word_q;
  // Result register
  logic                        out_valid_q, out_valid_d;
  cpsp_pkg::result_t           res_q, res_d;
  // Parser state
  cpsp_pkg::phase_e            phase_q, phase_d;
  logic [cpsp_pkg::CountW-1:0] words_left_q, words_left_d;
  logic [cpsp_pkg::WordW-1:0]  cnt_hi_q, cnt_hi_d;
  logic [cpsp_pkg::OpW-1:0]    op_q, op_d;
  logic [cpsp_pkg::AddrW-1:0]  addr_q, addr_d;

  logic                        in_accept;
  logic                        adv;

  // Move the input word into the result register whenever that slot frees up.
  assign adv       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // Classify one word against the current parser state.
  always_comb begin
    logic [cpsp_pkg::HdrTypeW-1:0] hdr_type;
    logic [cpsp_pkg::OpW-1:0]      hdr_op;
    logic [cpsp_pkg::AddrW-1:0]    hdr_addr;
    logic [cpsp_pkg::CntMsb:0]     hdr_cnt;
    logic [cpsp_pkg::CountW-1:0]   full_cnt;
    logic [cpsp_pkg::CountW-1:0]   left_dec;

    hdr_type = s1_word_q[cpsp_pkg::TypeMsb:cpsp_pkg::TypeLsb];
    hdr_op   = s1_word_q[cpsp_pkg::OpMsb:cpsp_pkg::OpLsb];
    hdr_addr = s1_word_q[cpsp_pkg::AddrMsb:cpsp_pkg::AddrLsb];
    hdr_cnt  = s1_word_q[cpsp_pkg::CntMsb:cpsp_pkg::CntLsb];
    full_cnt = {cnt_hi_q, s1_word_q};
    left_dec = (words_left_q == '0) ? '0 : words_left_q - 1'b1;

    phase_d      = phase_q;
    words_left_d = words_left_q;
    cnt_hi_d     = cnt_hi_q;
    op_d         = op_q;
    addr_d       = addr_q;

    res_d.kind    = cpsp_pkg::KIND_INVALID;
    res_d.op      = op_q;
    res_d.addr    = addr_q;
    res_d.word    = s1_word_q;
    res_d.pkt_end = 1'b0;
    res_d.halted  = 1'b0;

    case (phase_q)
      cpsp_pkg::PH_HEADER: begin
        if (hdr_type == cpsp_pkg::HdrPad) begin
          // Pad: nop at address zero, held fields untouched.
          res_d.kind    = cpsp_pkg::KIND_PAD;
          res_d.op      = '0;
          res_d.addr    = '0;
          res_d.pkt_end = 1'b1;
        end else if (hdr_type == cpsp_pkg::HdrType1) begin
          op_d       = hdr_op;
          addr_d     = hdr_addr;
          res_d.kind = cpsp_pkg::KIND_TYPE1;
          res_d.op   = hdr_op;
          res_d.addr = hdr_addr;
          if (hdr_cnt == '0) begin
            res_d.pkt_end = 1'b1;
          end else begin
            words_left_d = {{(cpsp_pkg::CountW-cpsp_pkg::CntMsb-1){1'b0}}, hdr_cnt};
            phase_d      = cpsp_pkg::PH_DATA;
          end
        end else if (hdr_type == cpsp_pkg::HdrType2) begin
          op_d       = hdr_op;
          addr_d     = hdr_addr;
          phase_d    = cpsp_pkg::PH_CNT_HI;
          res_d.kind = cpsp_pkg::KIND_TYPE2;
          res_d.op   = hdr_op;
          res_d.addr = hdr_addr;
        end else begin
          // Unknown type: halt until reset.
          phase_d      = cpsp_pkg::PH_HALTED;
          res_d.op     = '0;
          res_d.addr   = '0;
          res_d.halted = 1'b1;
        end
      end
      cpsp_pkg::PH_CNT_HI: begin
        cnt_hi_d   = s1_word_q;
        phase_d    = cpsp_pkg::PH_CNT_LO;
        res_d.kind = cpsp_pkg::KIND_COUNT;
      end
      cpsp_pkg::PH_CNT_LO: begin
        res_d.kind = cpsp_pkg::KIND_COUNT;
        if (full_cnt == '0) begin
          phase_d       = cpsp_pkg::PH_HEADER;
          res_d.pkt_end = 1'b1;
        end else begin
          words_left_d = full_cnt;
          phase_d      = cpsp_pkg::PH_DATA;
        end
      end
      cpsp_pkg::PH_DATA: begin
        words_left_d = left_dec;
        res_d.kind   = cpsp_pkg::KIND_DATA;
        if (left_dec == '0) begin
          phase_d       = cpsp_pkg::PH_HEADER;
          res_d.pkt_end = 1'b1;
        end
      end
      default: begin
        phase_d      = cpsp_pkg::PH_HALTED;
        res_d.op     = '0;
        res_d.addr   = '0;
        res_d.halted = 1'b1;
      end
    endcase
  end

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= cpsp_pkg::PH_HEADER;
      words_left_q <= '0;
      cnt_hi_q     <= '0;
      op_q         <= '0;
      addr_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        phase_q      <= phase_d;
        words_left_q <= words_left_d;
        cnt_hi_q     <= cnt_hi_d;
        op_q         <= op_d;
        addr_q       <= addr_d;
      end
    end
  end

  // Payload registers: load on request accept / advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q <= word_in_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_kind_o   = res_q.kind;
  assign op_code_o     = res_q.op;
  assign reg_address_o = res_q.addr;
  assign word_out_o    = res_q.word;
  assign packet_end_o  = res_q.pkt_end;
  assign halted_o      = res_q.halted;

`ifndef SYNTH
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cpsp_pkg::PH_HALTED |=> phase_q == cpsp_pkg::PH_HALTED)
    else $error("parser left halted phase without reset");

  a_data_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cpsp_pkg::PH_DATA |-> words_left_q != '0)
    else $error("data phase with no words left");

  a_halt_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.halted |-> res_q.kind == cpsp_pkg::KIND_INVALID && !res_q.pkt_end)
    else $error("halted result not tagged invalid");

  a_adv_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced word did not reach result register");
`endif

endmodule
